// ===== design/ptrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrc_pkg
// Shared widths, thresholds, codes and classification functions for the
// pressure trend and rain classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrc_pkg;

  // history depth and derived widths
  localparam int DEPTH   = 18;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int H_W     = 10;
  localparam int P_W     = 14;
  localparam int T_W     = 32;
  localparam int C_W     = 16;
  localparam int R_W     = 7;

  // history entry: {pressure, time}
  localparam int ENTRY_W = P_W + T_W;

  // 3 h in ms (10 800 000) times 10 for 0.1 hPa -> 0.01 hPa
  localparam int SCALE_W = 27;
  localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(108000000);
  localparam int PROD_W  = P_W + SCALE_W;

  localparam logic signed [C_W-1:0] C_MAX = 16'sd32767;
  localparam logic signed [C_W-1:0] C_MIN = -16'sd32768;

  typedef enum logic [2:0] {
    TR_RISE_FAST = 3'd0,
    TR_RISE      = 3'd1,
    TR_STABLE    = 3'd2,
    TR_FALL      = 3'd3,
    TR_FALL_FAST = 3'd4
  } trend_t;

  typedef enum logic [2:0] {
    SKY_CLEAR    = 3'd0,
    SKY_PARTLY   = 3'd1,
    SKY_CLOUDY   = 3'd2,
    SKY_OVERCAST = 3'd3,
    SKY_LIGHT    = 3'd4,
    SKY_RAIN     = 3'd5,
    SKY_HEAVY    = 3'd6,
    SKY_STORM    = 3'd7
  } sky_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  function automatic trend_t trend_of(logic signed [C_W-1:0] c);
    trend_t t;
    if (c > 16'sd400)       t = TR_RISE_FAST;
    else if (c > 16'sd150)  t = TR_RISE;
    else if (c > -16'sd150) t = TR_STABLE;
    else if (c > -16'sd400) t = TR_FALL;
    else                    t = TR_FALL_FAST;
    return t;
  endfunction

  function automatic logic [R_W-1:0] rain_of(logic [H_W-1:0] h, logic [P_W-1:0] p,
                                             logic signed [C_W-1:0] c);
    logic signed [7:0] s;
    logic [R_W-1:0]    r;
    s = 8'sd0;
    if (h >= 10'd950)      s = s + 8'sd60;
    else if (h >= 10'd900) s = s + 8'sd45;
    else if (h >= 10'd850) s = s + 8'sd30;
    else if (h >= 10'd800) s = s + 8'sd20;
    else if (h >= 10'd700) s = s + 8'sd10;
    else if (h >= 10'd600) s = s + 8'sd5;

    if (p < 14'd10000)      s = s + 8'sd25;
    else if (p < 14'd10050) s = s + 8'sd15;
    else if (p < 14'd10100) s = s + 8'sd10;
    else if (p > 14'd10200) s = s - 8'sd15;
    else if (p > 14'd10150) s = s - 8'sd10;

    if (c < -16'sd600)      s = s + 8'sd35;
    else if (c < -16'sd400) s = s + 8'sd25;
    else if (c < -16'sd200) s = s + 8'sd15;
    else if (c < -16'sd100) s = s + 8'sd8;
    else if (c > 16'sd300)  s = s - 8'sd15;
    else if (c > 16'sd150)  s = s - 8'sd10;

    if (s < 8'sd0)        r = '0;
    else if (s > 8'sd100) r = R_W'(100);
    else                  r = s[R_W-1:0];
    return r;
  endfunction

  function automatic sky_t sky_of(logic [H_W-1:0] h, logic [P_W-1:0] p,
                                  logic [R_W-1:0] r);
    sky_t k;
    if (r >= 7'd85 && p < 14'd10000)   k = SKY_STORM;
    else if (r >= 7'd75)               k = SKY_HEAVY;
    else if (r >= 7'd55)               k = SKY_RAIN;
    else if (r >= 7'd40)               k = SKY_LIGHT;
    else if (h >= 10'd850 && r >= 7'd25) k = SKY_OVERCAST;
    else if (h >= 10'd700 || r >= 7'd20) k = SKY_CLOUDY;
    else if (h >= 10'd500)             k = SKY_PARTLY;
    else                               k = SKY_CLEAR;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/ptrc_in_if.sv =====
// ----------------------------------------------------------------------------
// ptrc_in_if
// Sample request channel: humidity, pressure and timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptrc_in_if
  import ptrc_pkg::*;
;
  logic           valid;
  logic           ready;
  logic [H_W-1:0] humidity;
  logic [P_W-1:0] pressure;
  logic [T_W-1:0] sample_time_ms;

  modport source (output valid, output humidity, output pressure,
                  output sample_time_ms, input ready);
  modport sink   (input valid, input humidity, input pressure,
                  input sample_time_ms, output ready);
endinterface

`default_nettype wire

// ===== design/ptrc_out_if.sv =====
// ----------------------------------------------------------------------------
// ptrc_out_if
// Result request channel: change, trend, rain score and sky code.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptrc_out_if
  import ptrc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic signed [C_W-1:0] press_change;
  logic [2:0]            trend_class;
  logic [R_W-1:0]        rain_score;
  logic [2:0]            sky_code;

  modport source (output valid, output press_change, output trend_class,
                  output rain_score, output sky_code, input ready);
  modport sink   (input valid, input press_change, input trend_class,
                  input rain_score, input sky_code, output ready);
endinterface

`default_nettype wire

// ===== design/pressure_trend_rain_classifier.sv =====
// ----------------------------------------------------------------------------
// pressure_trend_rain_classifier
// Ring history of pressure/time samples, 3 h pressure change by serial
// division, trend class, rain score and sky code per sample.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    humidity, pressure, sample_time_ms
//  out_ch   out  valid/ready    press_change, trend_class, rain_score, sky_code
//
//  One request at a time; the pressure change is computed by the 41-step
//  serial divider (one quotient bit per cycle).
//  in_ch.ready is high whenever the engine is idle; a finished result waits
//  in the output register, so a new request is taken while it is unread.
//  Synchronous active-low reset clears the slot pointer, fill count, FSM
//  and output valid; history RAM contents are not cleared (read only once
//  written). A stalled out_ch holds the engine in its last state.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_trend_rain_classifier
  import ptrc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptrc_in_if.sink    in_ch,
  ptrc_out_if.source out_ch
);

  state_t state_r, state_nxt;

  // history bookkeeping
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  held_r;
  logic [SLOT_W-1:0] slot_inc;
  logic [CNT_W-1:0]  held_inc;
  logic [SLOT_W-1:0] oldest;

  // latched request
  logic [H_W-1:0] hum_r;
  logic [P_W-1:0] pres_r;
  logic [T_W-1:0] time_r;
  logic           few_r;

  // RAM
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [P_W-1:0]     old_p;
  logic [T_W-1:0]     old_t;

  // change datapath
  logic [P_W:0]   diff;
  logic [T_W-1:0] dt;
  logic [P_W-1:0] mag_r;
  logic           neg_r;
  logic [T_W-1:0] dt_r;
  logic           zero_r;
  logic           div_start;
  logic           div_done;
  logic [PROD_W-1:0] quo;
  logic signed [C_W-1:0] chg_r;
  logic signed [C_W-1:0] chg_sat;

  // output register
  logic                  out_valid_r;
  logic signed [C_W-1:0] out_chg_r;
  trend_t                out_trend_r;
  logic [R_W-1:0]        out_rain_r;
  sky_t                  out_sky_r;
  logic [R_W-1:0]        rain;
  logic                  accept;
  logic                  load_out;

  assign accept = in_ch.valid && in_ch.ready;

  // Ring pointer and saturating fill count. Until the ring fills the
  // oldest entry is slot 0; once full it is the slot after the newest.
  always_comb begin
    slot_inc = (slot_r == SLOT_W'(DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
    held_inc = (held_r == CNT_W'(DEPTH)) ? held_r : held_r + CNT_W'(1);
    oldest   = (held_inc == CNT_W'(DEPTH)) ? slot_inc : '0;
  end

  assign ram_we = accept;

  // Write of the new sample and read of the oldest hit different slots
  // whenever two or more are held; with one held the read is unused.
  ptrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata ({in_ch.pressure, in_ch.sample_time_ms}),
    .re    (accept),
    .raddr (oldest),
    .rdata (ram_rdata)
  );

  assign old_p = ram_rdata[ENTRY_W-1:T_W];
  assign old_t = ram_rdata[T_W-1:0];

  ptrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PROD_W'(mag_r) * PROD_W'(SCALE)),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quo)
  );

  // signed delta and elapsed time (mod 2^32)
  always_comb begin
    diff = {1'b0, pres_r} - {1'b0, old_p};
    dt   = time_r - old_t;
  end

  // truncated magnitude quotient, sign restored, saturated
  always_comb begin
    if (zero_r) begin
      chg_sat = '0;
    end else if (!neg_r) begin
      chg_sat = (quo > PROD_W'(32767)) ? C_MAX : $signed(quo[C_W-1:0]);
    end else begin
      chg_sat = (quo > PROD_W'(32768)) ? C_MIN : -$signed(quo[C_W-1:0]);
    end
  end

  assign rain     = rain_of(hum_r, pres_r, chg_r);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // FSM next state and strobes
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // fewer than two held or zero elapsed time: no division
        if (zero_r) begin
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        slot_r <= slot_inc;
        held_r <= held_inc;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      hum_r  <= in_ch.humidity;
      pres_r <= in_ch.pressure;
      time_r <= in_ch.sample_time_ms;
      few_r  <= (held_r == '0);
    end
    if (state_r == ST_READ) begin
      neg_r  <= diff[P_W];
      mag_r  <= diff[P_W] ? P_W'(-diff) : diff[P_W-1:0];
      dt_r   <= dt;
      zero_r <= few_r || (dt == '0);
    end
    if (state_r == ST_FIN) begin
      chg_r <= chg_sat;
    end
    if (load_out) begin
      out_chg_r   <= chg_r;
      out_trend_r <= trend_of(chg_r);
      out_rain_r  <= rain;
      out_sky_r   <= sky_of(hum_r, pres_r, rain);
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.press_change = out_chg_r;
  assign out_ch.trend_class  = out_trend_r;
  assign out_ch.rain_score   = out_rain_r;
  assign out_ch.sky_code     = out_sky_r;

endmodule

`default_nettype wire

// ===== design/ptrc_ram.sv =====
// ----------------------------------------------------------------------------
// ptrc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/ptrc_div.sv =====
// ----------------------------------------------------------------------------
// ptrc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrc_div
  import ptrc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [T_W-1:0]    divisor,
  output      logic              done,
  output      logic [PROD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo_r;
  logic [T_W-1:0]    rem_r;
  logic [T_W-1:0]    dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [T_W:0]      rem_sh;
  logic [T_W:0]      rem_sub;
  logic              fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[PROD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    fits    = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit drops
      rem_r <= fits ? rem_sub[T_W-1:0] : rem_sh[T_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire
